FILE: hw/rtl/rhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel core.
// Holds the channel payload structs and the divider pipeline stage record.
// No dependencies.
package rhsv_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int FRACTION_BITS = 16;
    // Hue divisor is 6*C, which needs three bits above the channel width
    localparam int DIV_BITS      = PIXEL_BITS + 3;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic                  last_in;
    } t_pix_in;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] saturation;
        logic [PIXEL_BITS-1:0]    value_out;
        logic                     last_out;
    } t_hsv_out;

    // State of one item while it walks through the shared-step dividers
    typedef struct packed {
        logic                     gray;
        logic                     sat_full;
        logic                     last;
        logic [PIXEL_BITS-1:0]    value;
        logic [DIV_BITS-1:0]      div_h;
        logic [PIXEL_BITS-1:0]    rem_s;
        logic [DIV_BITS-1:0]      rem_h;
        logic [FRACTION_BITS-1:0] q_s;
        logic [FRACTION_BITS-1:0] q_h;
    } t_div_st;

endpackage

FILE: hw/rtl/rhsv_prep.sv
// Front stage of the RGB to HSV core: max, min, chroma, hue sector and
// hue numerator, registered into the first divider record.
// Depends on rhsv_pkg.
module rhsv_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rhsv_pkg::t_pix_in i_pix,
    output logic              o_valid,
    input  logic              i_ready,
    output rhsv_pkg::t_div_st o_st
);

    localparam int P  = rhsv_pkg::PIXEL_BITS;
    localparam int DW = rhsv_pkg::DIV_BITS;

    logic [P-1:0]  w_mx_rg, w_mn_rg, w_max, w_min, w_c;
    logic [DW-1:0] w_r, w_g, w_b, w_cw, w_d, w_t;
    rhsv_pkg::t_div_st n_st;
    rhsv_pkg::t_div_st r_st;
    logic r_valid;

    always_comb begin
        w_mx_rg = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        w_mn_rg = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        w_max   = (w_mx_rg > i_pix.blue) ? w_mx_rg : i_pix.blue;
        w_min   = (w_mn_rg < i_pix.blue) ? w_mn_rg : i_pix.blue;
        w_c     = w_max - w_min;
        w_r     = DW'(i_pix.red);
        w_g     = DW'(i_pix.green);
        w_b     = DW'(i_pix.blue);
        w_cw    = DW'(w_c);
        w_d     = (w_cw << 2) + (w_cw << 1);
        // Numerator already wrapped into one turn, so it lies in [0, 6C)
        if (i_pix.red == w_max) begin
            if (w_g >= w_b) begin
                w_t = w_g - w_b;
            end else begin
                w_t = w_d - (w_b - w_g);
            end
        end else if (i_pix.green == w_max) begin
            w_t = (w_cw << 1) + w_b - w_r;
        end else begin
            w_t = (w_cw << 2) + w_r - w_g;
        end

        n_st          = '0;
        n_st.gray     = (w_c == '0);
        n_st.sat_full = (w_c == w_max) && (w_c != '0);
        n_st.last     = i_pix.last_in;
        n_st.value    = w_max;
        n_st.div_h    = w_d;
        n_st.rem_s    = w_c;
        n_st.rem_h    = w_t;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

FILE: hw/rtl/rhsv_div_stage.sv
// One restoring-division step for both dividers (C/V and hue/6C),
// yielding one quotient bit each per stage, with its own handshake register.
// Depends on rhsv_pkg.
module rhsv_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rhsv_pkg::t_div_st i_st,
    output logic              o_valid,
    input  logic              i_ready,
    output rhsv_pkg::t_div_st o_st
);

    localparam int P  = rhsv_pkg::PIXEL_BITS;
    localparam int F  = rhsv_pkg::FRACTION_BITS;
    localparam int DW = rhsv_pkg::DIV_BITS;

    logic [P:0]  w_sh_s;
    logic [DW:0] w_sh_h;
    logic        w_ge_s, w_ge_h;
    rhsv_pkg::t_div_st n_st;
    rhsv_pkg::t_div_st r_st;
    logic r_valid;

    always_comb begin
        w_sh_s = {i_st.rem_s, 1'b0};
        w_sh_h = {i_st.rem_h, 1'b0};
        w_ge_s = (w_sh_s >= {1'b0, i_st.value});
        w_ge_h = (w_sh_h >= {1'b0, i_st.div_h});

        n_st       = i_st;
        n_st.rem_s = w_ge_s ? P'(w_sh_s - {1'b0, i_st.value}) : w_sh_s[P-1:0];
        n_st.rem_h = w_ge_h ? DW'(w_sh_h - {1'b0, i_st.div_h}) : w_sh_h[DW-1:0];
        n_st.q_s   = {i_st.q_s[F-2:0], w_ge_s};
        n_st.q_h   = {i_st.q_h[F-2:0], w_ge_h};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

FILE: hw/rtl/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel core: one pixel in, one HSV result out.
// Input channel: i_valid / o_ready with payload i_pix (red, green, blue,
// last_in). Output channel: o_valid / i_ready with payload o_hsv (hue,
// saturation, value_out, last_out). An item moves when valid and ready are
// both high at a rising edge of i_clk.
// Throughput: one item per cycle while the output is not stalled. Stages: one
// front stage for max/min and the hue numerator, one stage per quotient bit
// of the two restoring dividers, and one output register that applies the
// gray and full-saturation cases.
// Hue is a fraction of a turn, saturation is C/V with 1.0 shown as all ones.
// Stall: every stage holds its item while the stage after it is full and
// stalled; empty stages keep filling, so bubbles close up. o_ready drops only
// when every stage holds an item and i_ready is low. Nothing is lost or
// repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline; items in flight are
// dropped and o_valid is low in the cycle after.
// Depends on rhsv_pkg, rhsv_prep and rhsv_div_stage.
module rgb_to_hsv_pixel_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rhsv_pkg::t_pix_in  i_pix,
    output logic               o_valid,
    input  logic               i_ready,
    output rhsv_pkg::t_hsv_out o_hsv
);

    localparam int F = rhsv_pkg::FRACTION_BITS;

    logic              w_valid [0:F];
    logic              w_ready [0:F];
    rhsv_pkg::t_div_st w_st    [0:F];

    logic               w_out_ready;
    rhsv_pkg::t_hsv_out n_hsv;
    rhsv_pkg::t_hsv_out r_hsv;
    logic               r_out_valid;

    rhsv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_st    (w_st[0])
    );

    for (genvar k = 0; k < F; k++) begin : g_div
        rhsv_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_st    (w_st[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_st    (w_st[k+1])
        );
    end

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_ready[F]  = w_out_ready;

    always_comb begin
        n_hsv.value_out = w_st[F].value;
        n_hsv.last_out  = w_st[F].last;
        if (w_st[F].gray) begin
            n_hsv.hue        = '0;
            n_hsv.saturation = '0;
        end else begin
            n_hsv.hue        = w_st[F].q_h;
            n_hsv.saturation = w_st[F].sat_full ? '1 : w_st[F].q_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[F]) begin
            r_hsv <= n_hsv;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_hsv;

`ifndef SYNTHESIS
    // An empty or draining output register frees the whole ready chain
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side can move");

    // A black pixel has no chroma, so hue and saturation are zero
    a_black_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hsv.value_out == '0)) |->
        ((o_hsv.hue == '0) && (o_hsv.saturation == '0)))
        else $error("nonzero hue or saturation for black pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Full saturation only arises when the minimum channel is zero
    a_full_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[F] && w_st[F].sat_full) |-> (w_st[F].rem_s == w_st[F].value))
        else $error("saturation divider remainder broken for full chroma");
`endif

endmodule

FILE: bench/rgb_to_hsv_checker.sv
// Checker for the RGB to HSV pixel core: watches both channels, works out the
// HSV item for every accepted pixel and compares the results in arrival order.
// Depends on rhsv_pkg.
module rgb_to_hsv_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rhsv_pkg::t_pix_in  i_pix,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rhsv_pkg::t_hsv_out i_hsv,
    output int                 o_fail_count,
    output int                 o_pending
);

    rhsv_pkg::t_hsv_out hsv_due[$];
    int                 fail_total = 0;

    function automatic rhsv_pkg::t_hsv_out hsv_of_pixel(input rhsv_pkg::t_pix_in px);
        longint             r, g, b, v, lo, c, num, s, q;
        rhsv_pkg::t_hsv_out hsv;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        v  = r;
        if (g > v) v = g;
        if (b > v) v = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        c  = v - lo;
        hsv.hue        = '0;
        hsv.saturation = '0;
        hsv.value_out  = v[rhsv_pkg::PIXEL_BITS-1:0];
        hsv.last_out   = px.last_in;
        if (c != 0) begin
            s = (c << rhsv_pkg::FRACTION_BITS) / v;
            // a ratio of exactly one clips to all ones
            if (s >= (longint'(1) << rhsv_pkg::FRACTION_BITS)) begin
                hsv.saturation = '1;
            end else begin
                hsv.saturation = s[rhsv_pkg::FRACTION_BITS-1:0];
            end
            // first channel equal to the maximum picks the sector
            if (v == r) begin
                num = g - b;
            end else if (v == g) begin
                num = 2 * c + b - r;
            end else begin
                num = 4 * c + r - g;
            end
            // wrap a negative hue by one full turn
            if (num < 0) num = num + 6 * c;
            q       = (num << rhsv_pkg::FRACTION_BITS) / (6 * c);
            hsv.hue = q[rhsv_pkg::FRACTION_BITS-1:0];
        end
        return hsv;
    endfunction

    always @(posedge i_clk) begin
        rhsv_pkg::t_hsv_out want;
        if (!i_rst_n) begin
            hsv_due.delete();
        end else begin
            // check the output first: an item cannot leave in the cycle it enters
            if (i_out_valid && i_out_ready) begin
                if (hsv_due.size() == 0) begin
                    $error("unexpected HSV item: hue %0d sat %0d value %0d last %0d",
                           i_hsv.hue, i_hsv.saturation, i_hsv.value_out, i_hsv.last_out);
                    fail_total++;
                end else begin
                    want = hsv_due.pop_front();
                    if (i_hsv.hue !== want.hue) begin
                        $error("hue: expected %0d, actual %0d", want.hue, i_hsv.hue);
                        fail_total++;
                    end
                    if (i_hsv.saturation !== want.saturation) begin
                        $error("saturation: expected %0d, actual %0d",
                               want.saturation, i_hsv.saturation);
                        fail_total++;
                    end
                    if (i_hsv.value_out !== want.value_out) begin
                        $error("value_out: expected %0d, actual %0d",
                               want.value_out, i_hsv.value_out);
                        fail_total++;
                    end
                    if (i_hsv.last_out !== want.last_out) begin
                        $error("last_out: expected %0d, actual %0d",
                               want.last_out, i_hsv.last_out);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                hsv_due.push_back(hsv_of_pixel(i_pix));
            end
        end
        o_pending    <= hsv_due.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: bench/rgb_to_hsv_pixel_core_test.sv
// Testbench top for the RGB to HSV pixel core: drives pixels and back-pressure,
// gives the verdict. Prediction and comparison live in rgb_to_hsv_checker.
// Depends on rhsv_pkg, rgb_to_hsv_checker and rgb_to_hsv_pixel_core.
module rgb_to_hsv_pixel_core_test;

    localparam int PIXELS_PER_PHASE = 367;
    localparam int DRAIN_CYCLES     = 60;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    rhsv_pkg::t_pix_in  i_pix   = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    rhsv_pkg::t_hsv_out o_hsv;

    int fail_count;
    int pending_count;
    int send_idle_pct = 8;
    int recv_idle_pct = 60;

    rgb_to_hsv_pixel_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

    rgb_to_hsv_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_pix        (i_pix),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_hsv        (o_hsv),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic rhsv_pkg::t_pix_in pixel(input int r, input int g, input int b,
                                                 input bit l);
        rhsv_pkg::t_pix_in px;
        px.red     = r[rhsv_pkg::PIXEL_BITS-1:0];
        px.green   = g[rhsv_pkg::PIXEL_BITS-1:0];
        px.blue    = b[rhsv_pkg::PIXEL_BITS-1:0];
        px.last_in = l;
        return px;
    endfunction

    function automatic int edge_channel();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 1;
            2:       return 254;
            default: return 255;
        endcase
    endfunction

    // mostly uniform pixels, with grays, tied maxima and extreme codes mixed in
    function automatic rhsv_pkg::t_pix_in random_pixel();
        int hi, lo, kind;
        bit l;
        l    = ($urandom_range(15) == 0);
        kind = $urandom_range(9);
        hi   = $urandom_range(255);
        lo   = $urandom_range(hi);
        case (kind)
            0: return pixel(hi, hi, hi, l);
            1: begin
                case ($urandom_range(2))
                    0:       return pixel(hi, hi, lo, l);
                    1:       return pixel(hi, lo, hi, l);
                    default: return pixel(lo, hi, hi, l);
                endcase
            end
            2: return pixel(edge_channel(), edge_channel(), edge_channel(), l);
            default: return pixel($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255), l);
        endcase
    endfunction

    task automatic send_pixel(input rhsv_pkg::t_pix_in px);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_pix   <= px;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // hold the sender until every expected item has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                send_pixel(pixel(0, 0, 0, 1'b0));
                send_pixel(pixel(255, 255, 255, 1'b1));
                send_pixel(pixel(128, 128, 128, 1'b0));
                send_pixel(pixel(255, 0, 0, 1'b0));
                send_pixel(pixel(0, 255, 0, 1'b0));
                send_pixel(pixel(0, 0, 255, 1'b1));
                // tied maxima: red wins over green and blue, green over blue
                send_pixel(pixel(255, 255, 0, 1'b0));
                send_pixel(pixel(255, 0, 255, 1'b0));
                send_pixel(pixel(0, 255, 255, 1'b0));
                // red sector with green below blue wraps the hue
                send_pixel(pixel(255, 0, 10, 1'b0));
                send_pixel(pixel(255, 1, 254, 1'b1));
                send_pixel(pixel(200, 100, 101, 1'b0));
                send_pixel(pixel(1, 0, 0, 1'b0));
                send_pixel(pixel(0, 1, 0, 1'b0));
                send_pixel(pixel(0, 0, 1, 1'b0));
                send_pixel(pixel(1, 1, 0, 1'b1));
                send_pixel(pixel(254, 255, 0, 1'b0));
                send_pixel(pixel(200, 100, 50, 1'b0));
                send_pixel(pixel(50, 100, 200, 1'b0));
                send_pixel(pixel(100, 200, 50, 1'b0));
                send_pixel(pixel(255, 254, 254, 1'b1));
                send_pixel(pixel(1, 255, 254, 1'b0));
                drain_results();
            end

            repeat (PIXELS_PER_PHASE) send_pixel(random_pixel());
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
